/* rtl/core/bounded_list_engine_defines.svh */
// ---------------------------------------------------------------------------
// Bounded list engine assertion macros
// Shared property forms for the checker, clocked on clk and reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef BOUNDED_LIST_ENGINE_DEFINES_SVH
`define BOUNDED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication.
`define BLE_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bounded list engine: same-cycle check failed");

// Next-cycle implication.
`define BLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bounded list engine: next-cycle check failed");

`endif

/* rtl/core/ble_pkg.sv */
// ---------------------------------------------------------------------------
// Bounded list engine package
// Sizes, command and status codes, and the compare result type.
// ---------------------------------------------------------------------------
package ble_pkg;

    // List capacity and the widths that follow from it.
    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 64;

    // Command codes.
    typedef enum logic [2:0] {
        ACT_APPEND  = 3'd0,
        ACT_POP     = 3'd1,
        ACT_GET     = 3'd2,
        ACT_INSERT  = 3'd3,
        ACT_REMOVE  = 3'd4,
        ACT_FIND    = 3'd5,
        ACT_REVERSE = 3'd6,
        ACT_SORT    = 3'd7
    } action_t;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Result of the shared comparator.
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

/* rtl/core/ble_cmp.sv */
// ---------------------------------------------------------------------------
// Bounded list engine comparator
// Shared 64-bit equality and signed greater-than unit.
// ---------------------------------------------------------------------------
module ble_cmp (
    input  logic [ble_pkg::DATA_W-1:0] a,
    input  logic [ble_pkg::DATA_W-1:0] b,
    output ble_pkg::cmp_res_t          res
);
    import ble_pkg::*;

    // Bit-exact match and two's complement ordering.
    always_comb
    begin
        res.eq = (a == b);
        res.gt = ($signed(a) > $signed(b));
    end

endmodule

/* rtl/core/bounded_list_engine.sv */
// ---------------------------------------------------------------------------
// Bounded list engine
// Fixed-capacity ordered list of signed Q32.32 values with list commands.
// ---------------------------------------------------------------------------
// The input channel (in_valid/in_ready) carries one command word: action,
// value and index. The output channel (out_valid/out_ready) returns one
// result word per command: value_out, position, found, status, length.
// Commands run one at a time on a list memory with one write port and a
// registered read port, under a small sequencer that shares one comparator.
// in_ready is high only while the sequencer is idle. Append, errors and
// trivial reverse, sort or find finish without a read. Pop and get read
// one entry; insert shifts the entries from the index up by one; remove
// shifts the entries above the index down by one; find scans from the
// front until a match; reverse swaps pairs from both ends inward; sort is
// an insertion sort that shifts larger entries right past each key.
// Every memory read is registered, and a later state uses the data.
// A finished result sits in the output register while the next command is
// accepted; if that register is still full, the sequencer waits in its
// final state until out_ready frees it.
// Reset empties the list and drops any pending result; the memory itself
// is not cleared, since only entries below the count are ever read.
// ---------------------------------------------------------------------------
module bounded_list_engine (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [2:0]                 action,
    input  logic [ble_pkg::DATA_W-1:0] value,
    input  logic [ble_pkg::CW-1:0]     index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [ble_pkg::DATA_W-1:0] value_out,
    output logic [ble_pkg::AW-1:0]     position,
    output logic                       found,
    output logic [1:0]                 status,
    output logic [ble_pkg::CW-1:0]     length
);
    import ble_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_RD   = 10'b00_0000_0010,
        S_RJ   = 10'b00_0000_0100,
        S_EX   = 10'b00_0000_1000,
        S_WJ   = 10'b00_0001_0000,
        S_WV   = 10'b00_0010_0000,
        S_SK   = 10'b00_0100_0000,
        S_SR   = 10'b00_1000_0000,
        S_SW   = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } state_t;

    state_t            state_reg, state_next;
    action_t           op_reg, op_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     i_reg, i_next;
    logic [CW-1:0]     j_reg, j_next;
    logic [DATA_W-1:0] rvout_reg, rvout_next;
    logic [AW-1:0]     rpos_reg, rpos_next;
    logic              rfound_reg, rfound_next;
    logic [1:0]        rstatus_reg, rstatus_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] value_out_reg, value_out_next;
    logic [AW-1:0]     position_reg, position_next;
    logic              found_reg, found_next;
    logic [1:0]        status_reg, status_next;
    logic [CW-1:0]     length_reg, length_next;

    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] rd_reg;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic [AW-1:0]     raddr;

    logic [CW-1:0]     i_inc, i_dec, j_dec;
    logic [CW-1:0]     count_inc, count_dec;
    cmp_res_t          cmp;

    assign i_inc     = i_reg + 1'b1;
    assign i_dec     = i_reg - 1'b1;
    assign j_dec     = j_reg - 1'b1;
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;

    // Shared comparator: read word against the operand or sort key.
    ble_cmp u_cmp (
        .a   (rd_reg),
        .b   (val_reg),
        .res (cmp)
    );

    // List memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg <= mem[raddr];
    end

    // Read address for each sequencer step.
    always_comb
    begin
        unique case (state_reg)
            S_RD:    raddr = (op_reg == ACT_INSERT) ? i_dec[AW-1:0] : i_reg[AW-1:0];
            S_RJ:    raddr = j_reg[AW-1:0];
            S_SK:    raddr = i_dec[AW-1:0];
            S_SR:    raddr = j_dec[AW-1:0];
            default: raddr = i_reg[AW-1:0];
        endcase
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        val_next       = val_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        rvout_next     = rvout_reg;
        rpos_next      = rpos_reg;
        rfound_next    = rfound_reg;
        rstatus_next   = rstatus_reg;
        out_valid_next = out_valid_reg & ~out_ready;
        value_out_next = value_out_reg;
        position_next  = position_reg;
        found_next     = found_reg;
        status_next    = status_reg;
        length_next    = length_reg;
        we             = 1'b0;
        waddr          = '0;
        wdata          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next      = action_t'(action);
                    val_next     = value;
                    idx_next     = index;
                    rvout_next   = '0;
                    rpos_next    = '0;
                    rfound_next  = 1'b0;
                    rstatus_next = ST_OK;
                    state_next   = S_DONE;
                    unique case (action_t'(action))
                        ACT_APPEND:
                        begin
                            if (count_reg == CW'(CAPACITY))
                            begin
                                rstatus_next = ST_FULL;
                            end
                            else
                            begin
                                we         = 1'b1;
                                waddr      = count_reg[AW-1:0];
                                wdata      = value;
                                count_next = count_inc;
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                rstatus_next = ST_EMPTY;
                            end
                            else
                            begin
                                i_next     = count_dec;
                                count_next = count_dec;
                                state_next = S_RD;
                            end
                        end
                        ACT_GET, ACT_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                rstatus_next = ST_EMPTY;
                            end
                            else if (index >= count_reg)
                            begin
                                rstatus_next = ST_RANGE;
                            end
                            else
                            begin
                                i_next     = index;
                                state_next = S_RD;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (index > count_reg)
                            begin
                                rstatus_next = ST_RANGE;
                            end
                            else if (count_reg == CW'(CAPACITY))
                            begin
                                rstatus_next = ST_FULL;
                            end
                            else
                            begin
                                i_next     = count_reg;
                                state_next = (index == count_reg) ? S_WV : S_RD;
                            end
                        end
                        ACT_FIND:
                        begin
                            if (count_reg != '0)
                            begin
                                i_next     = '0;
                                state_next = S_RD;
                            end
                        end
                        ACT_REVERSE:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                i_next     = '0;
                                j_next     = count_dec;
                                state_next = S_RD;
                            end
                        end
                        ACT_SORT:
                        begin
                            if (count_reg > CW'(1))
                            begin
                                i_next     = CW'(1);
                                state_next = S_RD;
                            end
                        end
                    endcase
                end
            end

            // Read issued; choose how the data is used.
            S_RD:
            begin
                if (op_reg == ACT_REVERSE)
                begin
                    state_next = S_RJ;
                end
                else if (op_reg == ACT_SORT)
                begin
                    state_next = S_SK;
                end
                else
                begin
                    state_next = S_EX;
                end
            end

            // Reverse: hold the low word, read the high one.
            S_RJ:
            begin
                val_next   = rd_reg;
                state_next = S_EX;
            end

            // Sort: take the key and read its left neighbor.
            S_SK:
            begin
                val_next   = rd_reg;
                j_next     = i_reg;
                state_next = S_EX;
            end

            // Sort: read the next left neighbor.
            S_SR:
            begin
                state_next = S_EX;
            end

            // Use the registered read data.
            S_EX:
            begin
                unique case (op_reg)
                    ACT_POP, ACT_GET:
                    begin
                        rvout_next = rd_reg;
                        state_next = S_DONE;
                    end
                    ACT_INSERT:
                    begin
                        we     = 1'b1;
                        waddr  = i_reg[AW-1:0];
                        wdata  = rd_reg;
                        i_next = i_dec;
                        state_next = (i_dec > idx_reg) ? S_RD : S_WV;
                    end
                    ACT_REMOVE:
                    begin
                        if (i_reg == idx_reg)
                        begin
                            rvout_next = rd_reg;
                        end
                        else
                        begin
                            we    = 1'b1;
                            waddr = i_dec[AW-1:0];
                            wdata = rd_reg;
                        end
                        i_next = i_inc;
                        if (i_inc < count_reg)
                        begin
                            state_next = S_RD;
                        end
                        else
                        begin
                            count_next = count_dec;
                            state_next = S_DONE;
                        end
                    end
                    ACT_FIND:
                    begin
                        if (cmp.eq)
                        begin
                            rfound_next = 1'b1;
                            rpos_next   = i_reg[AW-1:0];
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            i_next     = i_inc;
                            state_next = (i_inc < count_reg) ? S_RD : S_DONE;
                        end
                    end
                    ACT_REVERSE:
                    begin
                        we         = 1'b1;
                        waddr      = i_reg[AW-1:0];
                        wdata      = rd_reg;
                        state_next = S_WJ;
                    end
                    ACT_SORT:
                    begin
                        if (cmp.gt)
                        begin
                            we     = 1'b1;
                            waddr  = j_reg[AW-1:0];
                            wdata  = rd_reg;
                            j_next = j_dec;
                            state_next = (j_reg > CW'(1)) ? S_SR : S_SW;
                        end
                        else
                        begin
                            state_next = S_SW;
                        end
                    end
                    ACT_APPEND:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Reverse: write the held low word at the high end.
            S_WJ:
            begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = val_reg;
                i_next = i_inc;
                j_next = j_dec;
                state_next = (i_inc < j_dec) ? S_RD : S_DONE;
            end

            // Insert: place the new word in the opened slot.
            S_WV:
            begin
                we         = 1'b1;
                waddr      = idx_reg[AW-1:0];
                wdata      = val_reg;
                count_next = count_inc;
                state_next = S_DONE;
            end

            // Sort: drop the key into place and move to the next key.
            S_SW:
            begin
                we     = 1'b1;
                waddr  = j_reg[AW-1:0];
                wdata  = val_reg;
                i_next = i_inc;
                state_next = (i_inc < count_reg) ? S_RD : S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    value_out_next = rvout_reg;
                    position_next  = rpos_reg;
                    found_next     = rfound_reg;
                    status_next    = rstatus_reg;
                    length_next    = count_reg;
                    state_next     = S_IDLE;
                end
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and working registers.
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        val_reg       <= val_next;
        idx_reg       <= idx_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        rvout_reg     <= rvout_next;
        rpos_reg      <= rpos_next;
        rfound_reg    <= rfound_next;
        rstatus_reg   <= rstatus_next;
        value_out_reg <= value_out_next;
        position_reg  <= position_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        length_reg    <= length_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign value_out = value_out_reg;
    assign position  = position_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign length    = length_reg;

endmodule

/* rtl/core/ble_chk.sv */
// ---------------------------------------------------------------------------
// Bounded list engine checker
// Port-level checks on the command and result channels, bound to the top.
// ---------------------------------------------------------------------------
`include "bounded_list_engine_defines.svh"

module ble_chk (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [ble_pkg::DATA_W-1:0] value_out,
    input logic                       found,
    input logic [1:0]                 status,
    input logic [ble_pkg::CW-1:0]     length
);
    import ble_pkg::*;

    // A held result word keeps its value until it is taken.
    `BLE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(value_out))

    // The engine is busy in the cycle after it takes a command.
    `BLE_ASSERT_NEXT(a_busy_after_cmd, in_valid && in_ready, !in_ready)

    // The reported length never exceeds the capacity.
    `BLE_ASSERT_NOW(a_length_cap, out_valid, length <= CW'(CAPACITY))

    // A failed command returns no value and no match.
    `BLE_ASSERT_NOW(a_err_clean, out_valid && (status != ST_OK), (value_out == '0) && !found)

    // A match comes only from find, which returns no value.
    `BLE_ASSERT_NOW(a_found_clean, out_valid && found, value_out == '0)

endmodule

bind bounded_list_engine ble_chk u_ble_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value_out (value_out),
    .found     (found),
    .status    (status),
    .length    (length)
);
